// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, compiled out when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FSI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define FSI_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define FSI_ASSERT(lbl, clk, rstn, prop)
`define FSI_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== src/fsi_pkg.sv =====
`timescale 1ns / 1ps
package fsi_pkg;

  localparam int GRID_POINTS = 256;
  localparam int AW          = $clog2(GRID_POINTS);

  typedef logic [63:0] word_t;
  typedef logic [62:0] coef_t;
  typedef logic [AW-1:0] addr_t;

  localparam word_t SIGN_WORD = 64'h8000_0000_0000_0000;
  localparam word_t MAX_WORD  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [2:0] CFG_CONV    = 3'd0;
  localparam logic [2:0] CFG_GRAD    = 3'd1;
  localparam logic [2:0] CFG_DIFF    = 3'd2;
  localparam logic [2:0] CFG_ELASTIC = 3'd3;
  localparam logic [2:0] CFG_LOAD    = 3'd4;
  localparam logic [2:0] CFG_STIFF   = 3'd5;

  localparam coef_t RST_CONV    = 63'd1709396984;
  localparam coef_t RST_GRAD    = 63'd854698492;
  localparam coef_t RST_DIFF    = 63'd1700849999;
  localparam coef_t RST_ELASTIC = 63'd1700849999;
  localparam coef_t RST_LOAD    = 63'd8590;
  localparam coef_t RST_STIFF   = 63'd850424999444480;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    logic  ovf;
    word_t p;
  } mul_rsp_t;

  // saturating add, flag in the top bit
  function automatic logic [64:0] sadd(word_t a, word_t b);
    word_t s;
    logic  ov;
    s  = a + b;
    ov = (a[63] == b[63]) && (s[63] != a[63]);
    return {ov, ov ? (a[63] ? SIGN_WORD : MAX_WORD) : s};
  endfunction

  function automatic logic [64:0] ssub(word_t a, word_t b);
    word_t d;
    logic  ov;
    d  = a - b;
    ov = (a[63] != b[63]) && (d[63] != a[63]);
    return {ov, ov ? (a[63] ? SIGN_WORD : MAX_WORD) : d};
  endfunction

  function automatic addr_t to_addr(logic [7:0] idx);
    logic [AW+7:0] t;
    t = {{AW{1'b0}}, idx};
    return t[AW-1:0];
  endfunction

endpackage

// ===== src/fsi_stencil_time_step_top.sv =====
// One-dimensional fluid-structure time stepper, Q32.32 grid of GRID_POINTS points.
// Input channel in_*: tuser holds the action (load, step, read), tdata the index
// and the load value. Every accepted word yields exactly one result word on out_*.
// A load or an unused action goes directly to the done state; a read first passes a
// read state that captures the RAM word. A step walks three passes over the interior
// points through one shared multiplier that builds each 64x64 product from four
// 32x32 partial products.
// One word is worked on at a time; in_tready is high only while idle.
// The result sits in an output register; a new word is taken while it waits,
// and a stalled receiver holds the next result back until the slot drains.
// Configuration: cfg_valid/cfg_ready write coefficient cfg_index; write only
// while idle. cfg_ready is always high.
// Reset (rst_n low, synchronous) loads default coefficients, then a clearing pass
// writes zero to every grid entry; in_tready stays low until it ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fsi_stencil_time_step_top import fsi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // index[7:0], value[71:8]
  input  logic [1:0]   in_tuser,   // action[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // fluid_out[63:0], displacement_out[127:64],
                                   // pressure_out[191:128], overflow[192], zero fill
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [62:0]  cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CAP  = 4'd2;
  localparam logic [3:0] S_GO   = 4'd3;
  localparam logic [3:0] S_WAIT = 4'd4;
  localparam logic [3:0] S_WB   = 4'd5;
  localparam logic [3:0] S_RDR  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;

  localparam logic [1:0] P_FLUID = 2'd0;
  localparam logic [1:0] P_DISP  = 2'd1;
  localparam logic [1:0] P_PRES  = 2'd2;

  logic [3:0] state_r;
  logic [1:0] pass_r, k_r;
  addr_t      j_r;
  word_t      wl_r, wc_r, wr_r, pl_r, pc_r, pr_r;
  word_t      t_r [4];
  logic       ovf_r, rd_ok_r;
  coef_t      conv_r, grad_r, diff_r, elastic_r, load_r, stiff_r;
  word_t      res_f_r, res_d_r, res_p_r;
  logic       res_o_r;
  word_t      out_f_r, out_d_r, out_p_r;
  logic       out_o_r, out_valid_r;

  logic [1:0] in_act;
  logic [7:0] in_idx;
  word_t      in_val;
  logic       in_acc, idx_ok;

  addr_t      raddr, waddr, wr_addr;
  logic       f_we, d_we, p_we;
  word_t      f_wdata, d_wdata, p_wdata;
  word_t      f_rdata, d_rdata, p_rdata, fq, dq, pq;

  mul_req_t   mreq;
  mul_rsp_t   mrsp;

  logic [64:0] a1, a2, lp, cl, pd;
  logic        lap_f, op_f;
  logic [64:0] s1, s2, s3, e1, e2;
  word_t       new_val;
  logic        wb_f;
  logic [1:0]  k_last;
  logic        last_pt;

  assign in_act    = in_tuser;
  assign in_idx    = in_tdata[7:0];
  assign in_val    = in_tdata[71:8];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign idx_ok    = (32'(in_idx) < 32'(GRID_POINTS));
  assign cfg_ready = 1'b1;

  assign fq = f_rdata;
  assign dq = d_rdata;
  assign pq = p_rdata;

  assign wr_addr = j_r - addr_t'(1);
  assign last_pt = (j_r == addr_t'(GRID_POINTS - 1));
  assign raddr   = (state_r == S_IDLE) ? to_addr(in_idx) : j_r;

  fsi_ram #(.WIDTH(64), .DEPTH(GRID_POINTS)) u_fluid (
    .clk(clk), .we(f_we), .waddr(waddr), .wdata(f_wdata), .raddr(raddr), .rdata(f_rdata)
  );
  fsi_ram #(.WIDTH(64), .DEPTH(GRID_POINTS)) u_disp (
    .clk(clk), .we(d_we), .waddr(waddr), .wdata(d_wdata), .raddr(raddr), .rdata(d_rdata)
  );
  fsi_ram #(.WIDTH(64), .DEPTH(GRID_POINTS)) u_pres (
    .clk(clk), .we(p_we), .waddr(waddr), .wdata(p_wdata), .raddr(raddr), .rdata(p_rdata)
  );

  fsi_qmul u_qmul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  // stencil terms
  always_comb begin
    a1    = ssub(wr_r, wc_r);
    a2    = ssub(wl_r, wc_r);
    lp    = sadd(a1[63:0], a2[63:0]);
    lap_f = a1[64] | a2[64] | lp[64];
    cl    = ssub(wc_r, wl_r);
    pd    = ssub(pr_r, pl_r);
  end

  always_comb begin
    mreq.start = (state_r == S_GO);
    mreq.a     = '0;
    mreq.b     = '0;
    op_f       = 1'b0;
    case (pass_r)
      P_FLUID: begin
        case (k_r)
          2'd0: begin
            mreq.a = {1'b0, diff_r};
            mreq.b = lp[63:0];
            op_f   = lap_f;
          end
          2'd1: begin
            mreq.a = wc_r;
            mreq.b = cl[63:0];
            op_f   = cl[64];
          end
          2'd2: begin
            mreq.a = {1'b0, conv_r};
            mreq.b = t_r[1];
          end
          default: begin
            mreq.a = {1'b0, grad_r};
            mreq.b = pd[63:0];
            op_f   = pd[64];
          end
        endcase
      end
      P_DISP: begin
        if (k_r == 2'd0) begin
          mreq.a = {1'b0, elastic_r};
          mreq.b = lp[63:0];
          op_f   = lap_f;
        end else begin
          mreq.a = {1'b0, load_r};
          mreq.b = pc_r;
        end
      end
      default: begin
        mreq.a = {1'b0, stiff_r};
        mreq.b = lp[63:0];
        op_f   = lap_f;
      end
    endcase
  end

  always_comb begin
    s1      = ssub(t_r[0], t_r[2]);
    s2      = ssub(s1[63:0], t_r[3]);
    s3      = sadd(wc_r, s2[63:0]);
    e1      = sadd(t_r[0], t_r[1]);
    e2      = sadd(wc_r, e1[63:0]);
    new_val = t_r[0];
    wb_f    = 1'b0;
    k_last  = 2'd0;
    case (pass_r)
      P_FLUID: begin
        new_val = s3[63:0];
        wb_f    = s1[64] | s2[64] | s3[64];
        k_last  = 2'd3;
      end
      P_DISP: begin
        new_val = e2[63:0];
        wb_f    = e1[64] | e2[64];
        k_last  = 2'd1;
      end
      default: begin
        new_val = t_r[0];
        wb_f    = 1'b0;
        k_last  = 2'd0;
      end
    endcase
  end

  // write port: clear after reset, load from idle, write back during a step
  always_comb begin
    f_we    = 1'b0;
    d_we    = 1'b0;
    p_we    = 1'b0;
    waddr   = wr_addr;
    f_wdata = new_val;
    d_wdata = new_val;
    p_wdata = new_val;
    if (state_r == S_IDLE) begin
      waddr   = to_addr(in_idx);
      f_wdata = in_val;
      d_wdata = '0;
      p_wdata = '0;
      if (in_acc && in_act == ACT_LOAD && idx_ok) begin
        f_we = 1'b1;
        d_we = 1'b1;
        p_we = 1'b1;
      end
    end else if (state_r == S_CLR) begin
      waddr   = j_r;
      f_wdata = '0;
      d_wdata = '0;
      p_wdata = '0;
      f_we    = 1'b1;
      d_we    = 1'b1;
      p_we    = 1'b1;
    end else if (state_r == S_WB) begin
      f_we = (pass_r == P_FLUID);
      d_we = (pass_r == P_DISP);
      p_we = (pass_r == P_PRES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r    <= RST_CONV;
      grad_r    <= RST_GRAD;
      diff_r    <= RST_DIFF;
      elastic_r <= RST_ELASTIC;
      load_r    <= RST_LOAD;
      stiff_r   <= RST_STIFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONV:    conv_r    <= cfg_data;
        CFG_GRAD:    grad_r    <= cfg_data;
        CFG_DIFF:    diff_r    <= cfg_data;
        CFG_ELASTIC: elastic_r <= cfg_data;
        CFG_LOAD:    load_r    <= cfg_data;
        CFG_STIFF:   stiff_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      pass_r      <= P_FLUID;
      k_r         <= 2'd0;
      j_r         <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          j_r <= j_r + addr_t'(1);
          if (last_pt) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res_f_r <= '0;
            res_d_r <= '0;
            res_p_r <= '0;
            res_o_r <= 1'b0;
            rd_ok_r <= idx_ok;
            case (in_act)
              ACT_STEP: begin
                ovf_r   <= 1'b0;
                pass_r  <= P_FLUID;
                j_r     <= '0;
                state_r <= S_RD;
              end
              ACT_READ: state_r <= S_RDR;
              default:  state_r <= S_DONE;
            endcase
          end
        end
        S_RDR: begin
          res_f_r <= rd_ok_r ? fq : '0;
          res_d_r <= rd_ok_r ? dq : '0;
          res_p_r <= rd_ok_r ? pq : '0;
          state_r <= S_DONE;
        end
        S_RD: state_r <= S_CAP;
        S_CAP: begin
          wl_r <= wc_r;
          wc_r <= wr_r;
          wr_r <= (pass_r == P_FLUID) ? fq : dq;
          pl_r <= pc_r;
          pc_r <= pr_r;
          pr_r <= pq;
          if (j_r < addr_t'(2)) begin
            j_r     <= j_r + addr_t'(1);
            state_r <= S_RD;
          end else begin
            k_r     <= 2'd0;
            state_r <= S_GO;
          end
        end
        S_GO: begin
          ovf_r   <= ovf_r | op_f;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (mrsp.done) begin
            t_r[k_r] <= mrsp.p;
            ovf_r    <= ovf_r | mrsp.ovf;
            if (k_r == k_last) begin
              state_r <= S_WB;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_GO;
            end
          end
        end
        S_WB: begin
          ovf_r <= ovf_r | wb_f;
          if (pass_r != P_PRES) begin
            wc_r <= new_val;
          end
          if (!last_pt) begin
            j_r     <= j_r + addr_t'(1);
            state_r <= S_RD;
          end else if (pass_r == P_PRES) begin
            res_o_r <= ovf_r | wb_f;
            state_r <= S_DONE;
          end else begin
            pass_r  <= pass_r + 2'd1;
            j_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_f_r     <= res_f_r;
            out_d_r     <= res_d_r;
            out_p_r     <= res_p_r;
            out_o_r     <= res_o_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_o_r, out_p_r, out_d_r, out_f_r};

  `FSI_NEVER(mul_start_busy, clk, rst_n, mreq.start && mrsp.busy)
  `FSI_ASSERT(result_from_done, clk, rst_n, $rose(out_tvalid) |-> $past(state_r) == S_DONE)
  `FSI_ASSERT(wb_interior, clk, rst_n, state_r == S_WB |-> (wr_addr != '0 && wr_addr != '1))

endmodule

// ===== src/fsi_ram.sv =====
`timescale 1ns / 1ps
module fsi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fsi_qmul.sv =====
`timescale 1ns / 1ps
module fsi_qmul import fsi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [2:0]   ph_r;
  word_t        ma_r, mb_r;
  logic         neg_r;
  logic [127:0] acc_r;
  word_t        p_r;
  logic         ovf_r, done_r;
  logic [31:0]  xa, yb;
  logic [63:0]  pp;

  always_comb begin
    xa = (ph_r == 3'd3 || ph_r == 3'd4) ? ma_r[63:32] : ma_r[31:0];
    yb = (ph_r == 3'd2 || ph_r == 3'd4) ? mb_r[63:32] : mb_r[31:0];
    pp = {32'd0, xa} * {32'd0, yb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        ma_r  <= req.a[63] ? (64'd0 - req.a) : req.a;
        mb_r  <= req.b[63] ? (64'd0 - req.b) : req.b;
        neg_r <= req.a[63] ^ req.b[63];
        acc_r <= '0;
        ph_r  <= 3'd1;
      end else begin
        case (ph_r)
          3'd1: begin
            acc_r <= acc_r + {64'd0, pp};
            ph_r  <= 3'd2;
          end
          3'd2, 3'd3: begin
            acc_r <= acc_r + {32'd0, pp, 32'd0};
            ph_r  <= ph_r + 3'd1;
          end
          3'd4: begin
            acc_r <= acc_r + {pp, 64'd0};
            ph_r  <= 3'd5;
          end
          3'd5: begin
            if (neg_r) begin
              acc_r <= ~acc_r + 128'd1;
            end
            ph_r <= 3'd6;
          end
          3'd6: begin
            if (acc_r[127]) begin
              if (acc_r[127:96] != 32'hFFFF_FFFF || !acc_r[95]) begin
                p_r   <= SIGN_WORD;
                ovf_r <= 1'b1;
              end else begin
                p_r   <= acc_r[95:32];
                ovf_r <= 1'b0;
              end
            end else begin
              if (acc_r[127:96] != 32'd0 || acc_r[95]) begin
                p_r   <= MAX_WORD;
                ovf_r <= 1'b1;
              end else begin
                p_r   <= acc_r[95:32];
                ovf_r <= 1'b0;
              end
            end
            done_r <= 1'b1;
            ph_r   <= 3'd0;
          end
          default: ph_r <= 3'd0;
        endcase
      end
    end
  end

  assign rsp.busy = (ph_r != 3'd0);
  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.p    = p_r;

endmodule

// ===== dv/fsi_step_checker.sv =====
`timescale 1ns / 1ps
module fsi_step_checker import fsi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [71:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [199:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [62:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef logic signed [63:0] sword_t;

  typedef struct {
    word_t fluid;
    word_t disp;
    word_t pres;
    logic  ovf;
  } grid_word_t;

  word_t fluid_grid [GRID_POINTS];
  word_t disp_grid  [GRID_POINTS];
  word_t pres_grid  [GRID_POINTS];
  word_t k_conv, k_grad, k_diff, k_elastic, k_load, k_stiff;
  logic  clipped;
  grid_word_t due_words [$];

  function automatic word_t clip_sum(sword_t a, sword_t b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      clipped = 1'b1;
      return s[64] ? SIGN_WORD : MAX_WORD;
    end
    return s[63:0];
  endfunction

  function automatic word_t clip_diff(sword_t a, sword_t b);
    logic signed [64:0] d;
    d = a - b;
    if (d[64] != d[63]) begin
      clipped = 1'b1;
      return d[64] ? SIGN_WORD : MAX_WORD;
    end
    return d[63:0];
  endfunction

  // Q32.32 product, floored, clipped to 64 bits
  function automatic word_t fix_mul(sword_t a, sword_t b);
    logic signed [127:0] p;
    logic signed [127:0] r;
    p = a * b;
    r = p >>> 32;
    if (r[127:63] != {65{r[63]}}) begin
      clipped = 1'b1;
      return r[127] ? SIGN_WORD : MAX_WORD;
    end
    return r[63:0];
  endfunction

  function automatic word_t curvature(word_t l, word_t c, word_t r);
    return clip_sum(clip_diff(r, c), clip_diff(l, c));
  endfunction

  function automatic void advance_grid();
    word_t c, l, r, conv, grad, diff, el, ld;
    for (int i = 1; i < GRID_POINTS - 1; i++) begin
      c    = fluid_grid[i];
      l    = fluid_grid[i-1];
      r    = fluid_grid[i+1];
      conv = fix_mul(k_conv, fix_mul(c, clip_diff(c, l)));
      grad = fix_mul(k_grad, clip_diff(pres_grid[i+1], pres_grid[i-1]));
      diff = fix_mul(k_diff, curvature(l, c, r));
      fluid_grid[i] = clip_sum(c, clip_diff(clip_diff(diff, conv), grad));
    end
    for (int i = 1; i < GRID_POINTS - 1; i++) begin
      c  = disp_grid[i];
      el = fix_mul(k_elastic, curvature(disp_grid[i-1], c, disp_grid[i+1]));
      ld = fix_mul(k_load, pres_grid[i]);
      disp_grid[i] = clip_sum(c, clip_sum(el, ld));
    end
    for (int i = 1; i < GRID_POINTS - 1; i++)
      pres_grid[i] = fix_mul(k_stiff, curvature(disp_grid[i-1], disp_grid[i], disp_grid[i+1]));
  endfunction

  function automatic grid_word_t predict_word(logic [1:0] act, logic [7:0] idx, word_t val);
    grid_word_t w;
    w = '{fluid: '0, disp: '0, pres: '0, ovf: 1'b0};
    case (act)
      ACT_LOAD: begin
        fluid_grid[idx] = val;
        disp_grid[idx]  = '0;
        pres_grid[idx]  = '0;
      end
      ACT_STEP: begin
        clipped = 1'b0;
        advance_grid();
        w.ovf = clipped;
      end
      ACT_READ: begin
        w.fluid = fluid_grid[idx];
        w.disp  = disp_grid[idx];
        w.pres  = pres_grid[idx];
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic report(string what, word_t got, word_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grid_word_t w;
    if (!rst_n) begin
      k_conv    = {1'b0, RST_CONV};
      k_grad    = {1'b0, RST_GRAD};
      k_diff    = {1'b0, RST_DIFF};
      k_elastic = {1'b0, RST_ELASTIC};
      k_load    = {1'b0, RST_LOAD};
      k_stiff   = {1'b0, RST_STIFF};
      for (int i = 0; i < GRID_POINTS; i++) begin
        fluid_grid[i] = '0;
        disp_grid[i]  = '0;
        pres_grid[i]  = '0;
      end
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONV:    k_conv    = {1'b0, cfg_data};
          CFG_GRAD:    k_grad    = {1'b0, cfg_data};
          CFG_DIFF:    k_diff    = {1'b0, cfg_data};
          CFG_ELASTIC: k_elastic = {1'b0, cfg_data};
          CFG_LOAD:    k_load    = {1'b0, cfg_data};
          CFG_STIFF:   k_stiff   = {1'b0, cfg_data};
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (due_words.size() == 0) begin
          report("unexpected word", out_tdata[63:0], '0);
        end else begin
          w = due_words.pop_front();
          if (out_tdata[63:0] !== w.fluid) report("fluid", out_tdata[63:0], w.fluid);
          if (out_tdata[127:64] !== w.disp) report("displacement", out_tdata[127:64], w.disp);
          if (out_tdata[191:128] !== w.pres) report("pressure", out_tdata[191:128], w.pres);
          if (out_tdata[192] !== w.ovf) report("overflow", 64'(out_tdata[192]), 64'(w.ovf));
        end
      end
      if (in_tvalid && in_tready)
        due_words.push_back(predict_word(in_tuser, in_tdata[7:0], in_tdata[71:8]));
    end
    pending = due_words.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import fsi_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 60000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;   // index[7:0], value[71:8]
  logic [1:0]   in_tuser = '0;   // action[1:0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [199:0] out_tdata;       // fluid[63:0], displacement[127:64], pressure[191:128], overflow[192]
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [62:0]  cfg_data = '0;

  int fail_count, pending;
  int idle_cycles = 0;
  int n_load = 0, n_step = 0, n_read = 0, n_none = 0, n_cfg = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fsi_stencil_time_step_top u_top (.*);

  fsi_step_checker u_chk (.*);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_word(logic [1:0] act, logic [7:0] idx, word_t val);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {val, idx};
    do @(posedge clk); while (!in_tready);
    case (act)
      ACT_LOAD: n_load++;
      ACT_STEP: n_step++;
      ACT_READ: n_read++;
      default:  n_none++;
    endcase
  endtask

  task automatic write_coef(logic [2:0] idx, coef_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic word_t pick_value();
    word_t w;
    case ($urandom_range(0, 5))
      0: w = {$urandom, $urandom};
      1: begin
        case ($urandom_range(0, 4))
          0: w = MAX_WORD;
          1: w = SIGN_WORD;
          2: w = '0;
          3: w = '1;
          default: w = 64'd1;
        endcase
      end
      default: begin
        w = {32'd0, $urandom} + (64'($urandom_range(0, 7)) << 32);
        if ($urandom_range(0, 1)) w = -w;
      end
    endcase
    return w;
  endfunction

  task automatic apply_coefs(int kind);
    coef_t v;
    for (int i = CFG_CONV; i <= CFG_STIFF; i++) begin
      case (kind)
        0: case (i)
          CFG_CONV:    v = RST_CONV;
          CFG_GRAD:    v = RST_GRAD;
          CFG_DIFF:    v = RST_DIFF;
          CFG_ELASTIC: v = RST_ELASTIC;
          CFG_LOAD:    v = RST_LOAD;
          default:     v = RST_STIFF;
        endcase
        1: v = '0;
        2: v = '1;
        3: v = 63'($urandom_range(0, 32'h7FFF_FFFF));
        default: v = 63'({$urandom, $urandom});
      endcase
      write_coef(3'(i), v);
    end
  endtask

  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)       push_word(ACT_STEP, 8'($urandom), {$urandom, $urandom});
    else if (r < 6)  push_word(ACT_NONE, 8'($urandom), {$urandom, $urandom});
    else if (r < 50) push_word(ACT_LOAD, 8'($urandom), pick_value());
    else             push_word(ACT_READ, 8'($urandom), {$urandom, $urandom});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_word(ACT_READ, 8'd7, '0);
    push_word(ACT_LOAD, 8'd0, MAX_WORD);
    push_word(ACT_LOAD, 8'd1, SIGN_WORD);
    push_word(ACT_LOAD, 8'd2, '1);
    push_word(ACT_LOAD, 8'd3, 64'h0000_0002_8000_0000);
    push_word(ACT_LOAD, 8'd254, SIGN_WORD);
    push_word(ACT_LOAD, 8'd255, MAX_WORD);
    push_word(ACT_LOAD, 8'd128, 64'hFFFF_FFFD_0000_0000);
    push_word(ACT_READ, 8'd0, '0);
    push_word(ACT_READ, 8'd255, '0);
    push_word(ACT_STEP, 8'd0, '0);
    push_word(ACT_READ, 8'd1, '0);
    push_word(ACT_READ, 8'd2, '0);
    push_word(ACT_READ, 8'd3, '0);
    push_word(ACT_READ, 8'd127, '0);
    push_word(ACT_READ, 8'd254, '0);
    push_word(ACT_NONE, 8'hFF, '1);
    push_word(ACT_STEP, 8'hFF, '1);
    push_word(ACT_READ, 8'd128, '0);
    push_word(ACT_READ, 8'd129, '0);
    drain();

    for (int p = 0; p < 6; p++) begin
      apply_coefs(p == 5 ? 0 : (p + 1) % 5);
      if (p == 3) begin
        write_coef(3'd6, 63'({$urandom, $urandom}));
        write_coef(3'd7, 63'({$urandom, $urandom}));
      end
      if (p == 2) begin
        hold_req = 1'b1;
        repeat (30) push_word(ACT_READ, 8'($urandom), '0);
      end
      for (int k = 0; k < 125; k++) begin
        if (p == 5 && k == 25) quiet = 1'b1;
        random_word();
      end
      drain();
    end

    $display("covered %0d loads, %0d steps, %0d reads, %0d unused actions",
             n_load, n_step, n_read, n_none);
    $display("over %0d coefficient writes, from zero to full scale", n_cfg);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
